// File: sv/bb3_pkg.sv
// bb3_pkg: shared types, sizes and small lookup functions for the 3x3 box blur.
// Used by every module of the block but bb3_ram; depends on nothing.
package bb3_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W   = $clog2(MAX_DIM);
	localparam int SIZE_W  = 11;
	localparam int CH_W    = 16;
	localparam int PIX_W   = 3 * CH_W;
	localparam int COLV_W  = CH_W + 2;   // three-row column sum
	localparam int SUM_W   = CH_W + 4;   // nine-pixel window sum
	localparam int NSLOT   = 9;
	localparam int SLOT_W  = $clog2(NSLOT);
	localparam int QDEPTH  = 2;
	localparam int RECIP_W = 25;
	localparam int RECIP_SH = 24;

	// val[depth][age][channel]: depth 0/1/2 = 1/2/3 rows, age 0 = current column
	typedef struct packed {
		logic [DIM_W-1:0]                   row;
		logic [DIM_W-1:0]                   col;
		logic [NSLOT-1:0]                   mask;
		logic [2:0][2:0][2:0][COLV_W-1:0]   val;
	} job_t;

	// slot order: rows back 2,1,0 then cols back 2,1,0 (raster order of results)
	function automatic logic [1:0] slot_dr(input logic [SLOT_W-1:0] j);
		logic [1:0] r;
		case (j) inside
			[0:2]:   r = 2'd2;
			[3:5]:   r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] slot_dc(input logic [SLOT_W-1:0] j);
		logic [1:0] r;
		case (j) inside
			0, 3, 6: r = 2'd2;
			1, 4, 7: r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// ceil(2^24 / count); exact truncating divide for sums below 2^20
	function automatic logic [RECIP_W-1:0] slot_recip(input logic [SLOT_W-1:0] j);
		logic [RECIP_W-1:0] r;
		case (j) inside
			0:       r = 25'd1864136;   // /9
			1, 3:    r = 25'd2796203;   // /6
			2, 6:    r = 25'd5592406;   // /3
			4:       r = 25'd4194304;   // /4
			5, 7:    r = 25'd8388608;   // /2
			default: r = 25'd16777216;  // /1
		endcase
		return r;
	endfunction

endpackage

// File: sv/bb3_ram.sv
// bb3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/bb3_front.sv
// bb3_front: pixel intake, raster counters, line buffers and column sums.
// Emits one job per pixel that completes windows. Uses bb3_pkg and bb3_ram.
module bb3_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bb3_pkg::DIM_W-1:0] nm1,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [bb3_pkg::PIX_W-1:0] s_tdata,
	input  logic                     s_tuser,
	output logic                     push,
	output bb3_pkg::job_t            job,
	input  logic                     q_full
);
	import bb3_pkg::*;

	logic [DIM_W-1:0] row_q, col_q, r0, c0;
	logic             accept, fire;
	logic             v_s1, lrow_s1, lcol_s1;
	logic [DIM_W-1:0] row_s1, col_s1;
	logic [PIX_W-1:0] px_s1;
	logic [2*PIX_W-1:0] rd_word, word, wr_word, byp_data_q;
	logic             byp_q;
	logic [PIX_W-1:0] one, two;
	logic [2:0][1:0][2:0][COLV_W-1:0] hist_q;
	logic [2:0][2:0][COLV_W-1:0] col_new;
	logic [NSLOT-1:0] mask;

	// restart at frame start or when the position fell outside a shrunk frame
	always_comb begin
		r0 = row_q;
		c0 = col_q;
		if (s_tuser || row_q > nm1 || col_q > nm1) begin
			r0 = '0;
			c0 = '0;
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign fire     = v_s1 && (mask == '0 || !q_full);
	assign s_tready = !v_s1 || fire;
	assign push     = fire && (mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1  <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1  <= 1'b1;
				byp_q <= fire && (col_s1 == c0);
				if (c0 == nm1) begin
					col_q <= '0;
					row_q <= (r0 == nm1) ? '0 : r0 + 1'b1;
				end else begin
					col_q <= c0 + 1'b1;
					row_q <= r0;
				end
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1     <= r0;
			col_s1     <= c0;
			px_s1      <= s_tdata;
			lrow_s1    <= (r0 == nm1);
			lcol_s1    <= (c0 == nm1);
			byp_data_q <= wr_word;
		end
	end

	// word: upper half = previous row, lower half = two rows back
	bb3_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_DIM)) u_line (
		.clk     (clk),
		.wr_en   (fire),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_en   (accept),
		.rd_addr (c0),
		.rd_data (rd_word)
	);

	// a write landing on the same edge as the read is not seen by the RAM's registered read
	assign word    = byp_q ? byp_data_q : rd_word;
	assign one     = word[2*PIX_W-1:PIX_W];
	assign two     = word[PIX_W-1:0];
	assign wr_word = {px_s1, one};

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			col_new[0][ch] = COLV_W'(px_s1[ch*CH_W +: CH_W]);
			col_new[1][ch] = COLV_W'(px_s1[ch*CH_W +: CH_W]) + COLV_W'(one[ch*CH_W +: CH_W]);
			col_new[2][ch] = col_new[1][ch] + COLV_W'(two[ch*CH_W +: CH_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (fire) begin
			for (int d = 0; d < 3; d++) begin
				hist_q[d][1] <= hist_q[d][0];
				hist_q[d][0] <= col_new[d];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NSLOT; j++) begin
			mask[j] = (row_s1 >= DIM_W'(slot_dr(SLOT_W'(j))))
				&& (slot_dr(SLOT_W'(j)) == 2'd2 || lrow_s1)
				&& (col_s1 >= DIM_W'(slot_dc(SLOT_W'(j))))
				&& (slot_dc(SLOT_W'(j)) == 2'd2 || lcol_s1);
		end
		job.row  = row_s1;
		job.col  = col_s1;
		job.mask = mask;
		for (int d = 0; d < 3; d++) begin
			job.val[d][0] = col_new[d];
			job.val[d][1] = hist_q[d][0];
			job.val[d][2] = hist_q[d][1];
		end
	end

endmodule

// File: sv/bb3_queue.sv
// bb3_queue: short job queue between the front and back halves.
// Uses bb3_pkg for the job type and depth.
module bb3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bb3_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output bb3_pkg::job_t pop_job
);
	import bb3_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign valid   = (count_q != '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: sv/bb3_back.sv
// bb3_back: expands each job into its results in raster order, one per unstalled cycle.
// Sum stage then reciprocal-multiply stage into the output register. Uses bb3_pkg.
module bb3_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  bb3_pkg::job_t q_job,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [71:0]   m_tdata,  // out_row, out_col, red_out, green_out, blue_out, zero pad
	output logic          m_tlast   // burst_last
);
	import bb3_pkg::*;

	job_t             job_q;
	logic [NSLOT-1:0] rem_q, rem_nxt;
	logic             cur_v;
	logic [SLOT_W-1:0] sel;
	logic [1:0]       dr, dc;
	logic             last, a_load, b_load;
	logic [2:0][SUM_W-1:0] sum;

	logic             a_v, last_a;
	logic [DIM_W-1:0] row_a, col_a;
	logic [SLOT_W-1:0] slot_a;
	logic [2:0][SUM_W-1:0] sum_a;
	logic [RECIP_W-1:0] recip;
	logic [2:0][SUM_W+RECIP_W-1:0] prod;

	logic             b_v;

	always_comb begin
		sel = '0;
		for (int j = NSLOT - 1; j >= 0; j--) begin
			if (rem_q[j]) begin
				sel = SLOT_W'(j);
			end
		end
		rem_nxt      = rem_q;
		rem_nxt[sel] = 1'b0;
		last         = (rem_nxt == '0);
		dr           = slot_dr(sel);
		dc           = slot_dc(sel);
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = SUM_W'(job_q.val[dr][0][ch])
				+ ((dc != 2'd0) ? SUM_W'(job_q.val[dr][1][ch]) : '0)
				+ ((dc == 2'd2) ? SUM_W'(job_q.val[dr][2][ch]) : '0);
		end
	end

	assign b_load = a_v && (!b_v || m_tready);
	assign a_load = cur_v && (!a_v || b_load);
	assign pop    = q_valid && (!cur_v || (a_load && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v <= 1'b0;
			a_v   <= 1'b0;
			b_v   <= 1'b0;
		end else begin
			if (pop) begin
				cur_v <= 1'b1;
			end else if (a_load && last) begin
				cur_v <= 1'b0;
			end
			if (a_load) begin
				a_v <= 1'b1;
			end else if (b_load) begin
				a_v <= 1'b0;
			end
			if (b_load) begin
				b_v <= 1'b1;
			end else if (m_tready) begin
				b_v <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
			rem_q <= q_job.mask;
		end else if (a_load) begin
			rem_q <= rem_nxt;
		end
		if (a_load) begin
			row_a  <= job_q.row - DIM_W'(dr);
			col_a  <= job_q.col - DIM_W'(dc);
			sum_a  <= sum;
			slot_a <= sel;
			last_a <= last;
		end
	end

	assign recip = slot_recip(slot_a);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = (SUM_W+RECIP_W)'(sum_a[ch]) * (SUM_W+RECIP_W)'(recip);
		end
	end

	always_ff @(posedge clk) begin
		if (b_load) begin
			m_tdata <= {4'b0,
				prod[2][RECIP_SH +: CH_W],
				prod[1][RECIP_SH +: CH_W],
				prod[0][RECIP_SH +: CH_W],
				col_a, row_a};
			m_tlast <= last_a;
		end
	end

	assign m_tvalid = b_v;

endmodule

// File: sv/box_blur_3x3_truncated_edges.sv
// box_blur_3x3_truncated_edges: top level, frame size register and front/queue/back wiring.
// Depends on bb3_pkg, bb3_front, bb3_queue, bb3_back (and bb3_ram through the front).
//
//  channel  dir  beat contents (low bit up)                          handshake
//  s_       in   tdata: red_in, green_in, blue_in; tuser: frame_start  tvalid/tready
//  m_       out  tdata: out_row, out_col, red, green, blue; tlast      tvalid/tready
//  cfg_     in   wdata: frame_size                                     cfg_we
//
// One pixel per cycle enters while the job queue has room; each queued job passes through the
// job register, the sum register and the output register, leaving one result per cycle while
// the output is not stalled. A pixel that ends a row yields up to 3 results, the last pixel up
// to 9, so the output side sets the sustained rate at row ends. A pixel reaches its first
// result through the RAM read and column sums, the queue, the window sum and the divide.
// Reset clears counters, column sums and handshake state; line buffer contents stay unknown.
// Either side may stall independently through the two-entry job queue.
module box_blur_3x3_truncated_edges (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_row, out_col, red_out, green_out, blue_out, zero pad
	output logic        m_tlast,   // burst_last
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata  // frame_size
);
	import bb3_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0]  nm1;
	logic              push, q_full, pop, q_valid;
	job_t              job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_DIM);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// zero acts as one, anything above the max acts as the max
	always_comb begin
		if (size_q == '0) begin
			nm1 = '0;
		end else if (32'(size_q) > MAX_DIM) begin
			nm1 = DIM_W'(MAX_DIM - 1);
		end else begin
			nm1 = DIM_W'(size_q - 1'b1);
		end
	end

	bb3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.nm1      (nm1),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.job      (job),
		.q_full   (q_full)
	);

	bb3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_job  (q_job)
	);

	bb3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full && !pop))
		else $error("job queue overflow");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.mask != '0))
		else $error("job queued without results");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty job queue");

endmodule

// File: dv/tb_box_blur_3x3_truncated_edges.sv
// tb_box_blur_3x3_truncated_edges: self-checking bench for the 3x3 box blur with clipped edges.
// Predicts every blurred pixel from its own copy of line buffers and column sums.
// Depends on bb3_pkg and box_blur_3x3_truncated_edges.
`timescale 1ns / 1ps

class blur_scoreboard;
	typedef struct {
		logic [9:0]  row;
		logic [9:0]  col;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        last;
	} blur_px_t;

	blur_px_t       pending[$];
	int             errors;
	int unsigned    size_reg;
	int unsigned    row_cnt, col_cnt;
	logic [15:0]    line1[1024][3];
	logic [15:0]    line2[1024][3];
	int unsigned    colsum[6][3];

	function new();
		size_reg = 1024;
		row_cnt  = 0;
		col_cnt  = 0;
		errors   = 0;
		foreach (colsum[i, j]) colsum[i][j] = 0;
	endfunction

	function void set_size(int unsigned v);
		size_reg = v & 11'h7ff;
	endfunction

	// vertical sum over depth+1 rows ending at the current row
	function int unsigned vsum(int unsigned x, int unsigned depth, int ch);
		if (depth == 0)
			return line1[x][ch];
		return colsum[(x % 3) * 2 + depth - 1][ch];
	endfunction

	function void note_pixel(logic [15:0] px[3], logic fstart);
		int unsigned n, r0, c0, s2, sum, cnt;
		int dr, dc, k, first;
		blur_px_t e;
		n = size_reg;
		if (n < 1) n = 1;
		if (n > 1024) n = 1024;
		if (fstart) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		if (row_cnt >= n || col_cnt >= n) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		r0 = row_cnt;
		c0 = col_cnt;
		for (int ch = 0; ch < 3; ch++) begin
			s2 = line1[c0][ch] + px[ch];
			colsum[(c0 % 3) * 2][ch]     = s2;
			colsum[(c0 % 3) * 2 + 1][ch] = s2 + line2[c0][ch];
			line2[c0][ch] = line1[c0][ch];
			line1[c0][ch] = px[ch];
		end
		first = pending.size();
		k = 0;
		for (dr = 2; dr >= 0; dr--) begin
			if (r0 < dr) continue;
			if (dr != 2 && r0 != n - 1) continue;
			for (dc = 2; dc >= 0; dc--) begin
				if (c0 < dc) continue;
				if (dc != 2 && c0 != n - 1) continue;
				cnt   = (dr + 1) * (dc + 1);
				e.row = 10'(r0 - dr);
				e.col = 10'(c0 - dc);
				for (int ch = 0; ch < 3; ch++) begin
					sum = 0;
					for (int x = c0 - dc; x <= c0; x++) sum += vsum(x, dr, ch);
					case (ch)
						0: e.red   = 16'(sum / cnt);
						1: e.green = 16'(sum / cnt);
						default: e.blue = 16'(sum / cnt);
					endcase
				end
				e.last = 1'b0;
				pending.push_back(e);
				k++;
			end
		end
		if (k > 0) pending[first + k - 1].last = 1'b1;
		col_cnt = c0 + 1;
		if (col_cnt >= n) begin
			col_cnt = 0;
			row_cnt = r0 + 1;
			if (row_cnt >= n) row_cnt = 0;
		end
	endfunction

	function void check_result(logic [71:0] d, logic last);
		blur_px_t e;
		if (pending.size() == 0) begin
			$error("unexpected result beat row=%0d col=%0d", d[9:0], d[19:10]);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[9:0] !== e.row) begin
			$error("out_row exp %0d got %0d", e.row, d[9:0]);
			errors++;
		end
		if (d[19:10] !== e.col) begin
			$error("out_col exp %0d got %0d", e.col, d[19:10]);
			errors++;
		end
		if (d[35:20] !== e.red) begin
			$error("red_out exp %0d got %0d", e.red, d[35:20]);
			errors++;
		end
		if (d[51:36] !== e.green) begin
			$error("green_out exp %0d got %0d", e.green, d[51:36]);
			errors++;
		end
		if (d[67:52] !== e.blue) begin
			$error("blue_out exp %0d got %0d", e.blue, d[67:52]);
			errors++;
		end
		if (last !== e.last) begin
			$error("burst_last exp %0d got %0d", e.last, last);
			errors++;
		end
	endfunction
endclass

module tb_box_blur_3x3_truncated_edges;
	import bb3_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // red_in, green_in, blue_in
	logic        s_tuser = 1'b0; // frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // out_row, out_col, red_out, green_out, blue_out, pad
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	blur_scoreboard blur_sb = new();
	bit  idle_on = 1'b1;
	int  pixels_sent = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	logic        in_beat = 1'b0, out_beat = 1'b0;
	logic [71:0] out_data;
	logic        out_last;

	box_blur_3x3_truncated_edges DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// handshakes are sampled mid-cycle, after the edge's updates have settled
	always @(negedge clk) begin
		in_beat  <= s_tvalid && s_tready;
		out_beat <= m_tvalid && m_tready;
		out_data <= m_tdata;
		out_last <= m_tlast;
	end

	always @(posedge clk) begin
		if (out_beat && arst_n)
			blur_sb.check_result(out_data, out_last);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && arst_n && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("box_blur_3x3_truncated_edges: mismatch");
			$finish;
		end
	end

	function automatic logic [15:0] pick_channel();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic fs);
		logic [15:0] px[3];
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		s_tuser  <= fs;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		px[0] = r;
		px[1] = g;
		px[2] = b;
		blur_sb.note_pixel(px, fs);
		pixels_sent++;
	endtask

	// drain all results, let the pipeline settle, then write the frame size
	task automatic write_size(int unsigned v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (blur_sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= SIZE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		blur_sb.set_size(v);
	endtask

	task automatic send_frame(int unsigned n, bit restart_mid);
		int unsigned restart_at;
		restart_at = restart_mid ? $urandom_range(1, n * n - 1) : 0;
		for (int unsigned i = 0; i < n * n; i++)
			send_pixel(pick_channel(), pick_channel(), pick_channel(),
				i == 0 || (restart_mid && i == restart_at));
	endtask

	initial begin
		int unsigned n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pixel frames: each beat is its own window
		write_size(1);
		send_pixel(16'h0000, 16'hffff, 16'h0000, 1'b1);
		send_pixel(16'hffff, 16'h0000, 16'hffff, 1'b0);
		send_pixel(16'hffff, 16'hffff, 16'hffff, 1'b0);
		// 3x3 frame, all-max then zero red, max green and alternating blue to hit both sum extremes
		write_size(3);
		for (int i = 0; i < 9; i++)
			send_pixel(16'hffff, 16'hffff, 16'hffff, i == 0);
		for (int i = 0; i < 9; i++)
			send_pixel(16'h0000, 16'hffff, i[0] ? 16'hffff : 16'h0000, i == 0);
		// oversized setting clamps to the maximum; one partial row gives no results
		write_size(2047);
		for (int i = 0; i < 6; i++)
			send_pixel(pick_channel(), pick_channel(), pick_channel(), i == 0);
		// zero acts as one; position past the new edge wraps to the origin
		write_size(0);
		send_pixel(16'h1234, 16'hffff, 16'h0001, 1'b0);
		write_size(1024);
		send_pixel(16'h8000, 16'h7fff, 16'h0000, 1'b1);
		send_pixel(16'h0001, 16'hfffe, 16'haaaa, 1'b0);

		// large frames only early on so the run ends near the item target
		while (pixels_sent < 350) begin
			if (pixels_sent > 290) idle_on = 1'b0;
			case ($urandom_range(0, 9))
				0:       n = 1;
				1:       n = (pixels_sent < 100) ? $urandom_range(7, 11) : $urandom_range(2, 6);
				default: n = $urandom_range(2, 6);
			endcase
			write_size(n);
			repeat ((pixels_sent > 280) ? 1 : $urandom_range(1, 2))
				send_frame(n, n > 1 && $urandom_range(0, 5) == 0);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (blur_sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (blur_sb.errors == 0)
			$display("box_blur_3x3_truncated_edges: match");
		else
			$display("box_blur_3x3_truncated_edges: mismatch");
		$finish;
	end
endmodule

// File: filelist.f
sv/bb3_pkg.sv
sv/bb3_ram.sv
sv/bb3_front.sv
sv/bb3_queue.sv
sv/bb3_back.sv
sv/box_blur_3x3_truncated_edges.sv
dv/tb_box_blur_3x3_truncated_edges.sv
